>>> rtl/core/mwrpn_pkg.sv
// Package for the masked-width postfix evaluator: token and result item types,
// command and status codes, and sizing constants. No dependencies.
`timescale 1ns / 1ps

package mwrpn_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 64;
  localparam int unsigned NUM_VARS_DEF    = 20;
  localparam int unsigned ASSIGN_BITS     = 20;
  localparam int unsigned VAR_IDX_W       = $clog2(ASSIGN_BITS);
  localparam int unsigned WORD_W          = 64;
  localparam int unsigned HALF_W          = WORD_W / 2;
  localparam int unsigned BW_W            = 7;
  localparam int unsigned PADDR_W         = 3;
  localparam int unsigned PDATA_W         = 32;

  localparam logic [BW_W-1:0] BIT_WIDTH_RST = BW_W'(64);

  // Register index, taken from paddr[2]
  localparam logic REG_BIT_WIDTH = 1'b0;

  typedef enum logic [3:0] {
    CMD_PUSH_CONST = 4'd0,
    CMD_PUSH_VAR   = 4'd1,
    CMD_ADD        = 4'd2,
    CMD_SUB        = 4'd3,
    CMD_MUL        = 4'd4,
    CMD_AND        = 4'd5,
    CMD_OR         = 4'd6,
    CMD_XOR        = 4'd7,
    CMD_SHL        = 4'd8,
    CMD_SHR        = 4'd9,
    CMD_NOT        = 4'd10,
    CMD_NEG        = 4'd11
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_BAD_DEPTH = 2'd3
  } status_e;

  typedef struct packed {
    logic [3:0]             command;
    logic [WORD_W-1:0]      operand;
    logic [ASSIGN_BITS-1:0] assignment;
    logic                   last;
  } token_t;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    status_e           status;
  } result_t;

endpackage

>>> rtl/core/mwrpn_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read of an address written at the same edge returns the old data.
`timescale 1ns / 1ps

module mwrpn_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/masked_width_rpn_evaluator.sv
// Masked-width postfix evaluator top level: token execution, stack and APB register.
// Depends on mwrpn_pkg and mwrpn_ram.
//
//   channel  | direction | handshake                    | payload
//   ---------+-----------+------------------------------+------------------------------
//   in       | input     | in_valid_i / in_ready_o      | token_t  (command..last)
//   out      | output    | out_valid_o / out_ready_i    | result_t (value, status)
//   cfg      | APB slave | psel/penable/pwrite, pready  | bit_width at address 0
//
// One token per cycle unless ready drops. A mul token registers its partial products
// on acceptance and sums them in the pending state, during which ready is low.
// The top two stack entries live in registers; deeper entries sit in a RAM whose
// registered read always prefetches the entry below the second one.
// Reset clears depth, error, pending mul and output valid; the stack RAM is not
// cleared, since the depth guards every read. Bit width resets to 64.
// A finished result waits in the output register; non-last tokens keep flowing
// while it stalls, a last token waits until the output slot frees.
`timescale 1ns / 1ps

module masked_width_rpn_evaluator
  import mwrpn_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int unsigned NUM_VARS    = NUM_VARS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  token_t             in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output result_t            out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int unsigned DW        = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW        = $clog2(STACK_DEPTH);
  localparam int unsigned VAR_LIMIT = (NUM_VARS < ASSIGN_BITS) ? NUM_VARS : ASSIGN_BITS;

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [BW_W-1:0] bw_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bw_q <= BIT_WIDTH_RST;
    end else if (psel && penable && pwrite && (paddr[2] == REG_BIT_WIDTH)) begin
      bw_q <= pwdata[BW_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_BIT_WIDTH) ? PDATA_W'(bw_q) : '0;

  logic [WORD_W-1:0] mask;
  assign mask = (bw_q >= BW_W'(WORD_W)) ? '1
                                        : ((WORD_W'(1) << bw_q[5:0]) - WORD_W'(1));

  // ---------------------------------------------------------------------------
  // Stack state: top of stack, next on stack, RAM below
  // ---------------------------------------------------------------------------
  logic [WORD_W-1:0] tos_q, tos_d, nos_q, nos_d;
  logic [DW-1:0]     depth_q, depth_d;
  status_e           err_q, err_d;
  logic              pend_q, pend_d, pend_last_q, pend_last_d;
  logic [WORD_W-1:0] ll_q, ll_d;
  logic [HALF_W-1:0] cr_q, cr_d;
  logic              byp_q;
  logic [WORD_W-1:0] byp_data_q;
  logic              out_valid_q;
  result_t           out_data_q, res_d;
  logic              fin;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_rdata, third;
  logic [DW-1:0]     depth_m2, depth_d_m3;

  // A push writes exactly the entry that the next cycle prefetches; forward it.
  assign third = byp_q ? byp_data_q : ram_rdata;

  assign depth_m2   = depth_q - DW'(2);
  assign depth_d_m3 = depth_d - DW'(3);
  assign ram_waddr  = depth_m2[AW-1:0];
  assign ram_raddr  = depth_d_m3[AW-1:0];

  mwrpn_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (nos_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Hold off a last token while the output slot is full and not draining; stall during mul.
  assign in_ready_o = !pend_q && (!out_valid_q || out_ready_i || !in_data_i.last);

  logic accept;
  assign accept = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------------
  // Operand selection and ALU
  // ---------------------------------------------------------------------------
  logic [WORD_W-1:0] push_v, var_v, alu_r, prod;
  logic              big_shift;
  logic [3:0]        cmd;

  assign cmd       = in_data_i.command;
  assign big_shift = (tos_q >= WORD_W'(WORD_W)) || (tos_q >= WORD_W'(bw_q));
  assign var_v     = (in_data_i.operand < WORD_W'(VAR_LIMIT))
                     ? WORD_W'(in_data_i.assignment[in_data_i.operand[VAR_IDX_W-1:0]])
                     : '0;
  assign push_v    = ((cmd == CMD_PUSH_CONST) ? in_data_i.operand : var_v) & mask;
  assign prod      = ll_q + {cr_q, {HALF_W{1'b0}}};

  always_comb begin
    case (cmd)
      CMD_ADD: alu_r = nos_q + tos_q;
      CMD_SUB: alu_r = nos_q - tos_q;
      CMD_AND: alu_r = nos_q & tos_q;
      CMD_OR:  alu_r = nos_q | tos_q;
      CMD_XOR: alu_r = nos_q ^ tos_q;
      CMD_SHL: alu_r = big_shift ? '0 : (nos_q << tos_q[5:0]);
      CMD_SHR: alu_r = big_shift ? '0 : (nos_q >> tos_q[5:0]);
      CMD_NOT: alu_r = ~tos_q;
      CMD_NEG: alu_r = '0 - tos_q;
      default: alu_r = '0;
    endcase
  end

  // Partial products of the low 64 bits of nos * tos
  assign ll_d = WORD_W'(nos_q[HALF_W-1:0]) * WORD_W'(tos_q[HALF_W-1:0]);
  assign cr_d = HALF_W'(nos_q[HALF_W-1:0] * tos_q[WORD_W-1:HALF_W])
              + HALF_W'(nos_q[WORD_W-1:HALF_W] * tos_q[HALF_W-1:0]);

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    tos_d       = tos_q;
    nos_d       = nos_q;
    depth_d     = depth_q;
    err_d       = err_q;
    pend_d      = 1'b0;
    pend_last_d = pend_last_q;
    ram_we      = 1'b0;
    fin         = 1'b0;
    res_d       = '{value: '0, status: ST_OK};

    if (pend_q) begin
      // Finish the deferred mul: pop both, push the product
      tos_d   = prod & mask;
      nos_d   = third;
      depth_d = depth_q - DW'(1);
      fin     = pend_last_q;
    end else if (accept) begin
      fin = in_data_i.last;
      if (err_q == ST_OK) begin
        case (cmd)
          CMD_PUSH_CONST, CMD_PUSH_VAR: begin
            if (depth_q == DW'(STACK_DEPTH)) begin
              err_d = ST_OVERFLOW;
            end else begin
              ram_we  = (depth_q >= DW'(2));
              nos_d   = tos_q;
              tos_d   = push_v;
              depth_d = depth_q + DW'(1);
            end
          end
          CMD_NOT, CMD_NEG: begin
            if (depth_q == '0) begin
              err_d = ST_UNDERFLOW;
            end else begin
              tos_d = alu_r & mask;
            end
          end
          CMD_MUL: begin
            if (depth_q < DW'(2)) begin
              err_d = ST_UNDERFLOW;
            end else begin
              pend_d      = 1'b1;
              pend_last_d = in_data_i.last;
              fin         = 1'b0;
            end
          end
          CMD_ADD, CMD_SUB, CMD_AND, CMD_OR, CMD_XOR, CMD_SHL, CMD_SHR: begin
            if (depth_q < DW'(2)) begin
              err_d = ST_UNDERFLOW;
            end else begin
              tos_d   = alu_r & mask;
              nos_d   = third;
              depth_d = depth_q - DW'(1);
            end
          end
          default: begin
            // unused command codes leave the stack alone
          end
        endcase
      end
    end

    if (fin) begin
      if (err_d != ST_OK) begin
        res_d.status = err_d;
      end else if (depth_d != DW'(1)) begin
        res_d.status = ST_BAD_DEPTH;
      end else begin
        res_d.value = tos_d & mask;
      end
      // Clear for the next program
      depth_d = '0;
      err_d   = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q     <= '0;
      err_q       <= ST_OK;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
      byp_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      depth_q     <= depth_d;
      err_q       <= err_d;
      pend_q      <= pend_d;
      pend_last_q <= pend_last_d;
      byp_q       <= ram_we;
      if (fin) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    tos_q      <= tos_d;
    nos_q      <= nos_d;
    byp_data_q <= nos_q;
    if (pend_d) begin
      ll_q <= ll_d;
      cr_q <= cr_d;
    end
    if (fin) begin
      out_data_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_pend_stalls_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !in_ready_o)
    else $error("input taken while a mul is pending");

  a_pend_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |=> !pend_q)
    else $error("mul pending for more than one cycle");

  a_pend_no_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (err_q == ST_OK) && (depth_q >= DW'(2)))
    else $error("mul pending with error or shallow stack");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DW'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_error_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_data_q.status != ST_OK)) |-> (out_data_q.value == '0))
    else $error("nonzero value reported with error status");

endmodule
